// ===== rtl/towed_boat_dynamics_derivative_core_defines.svh =====
// assertion macros shared by the checker of the towed boat derivative core
// depends on nothing; included by the checker file only
`ifndef TOWED_BOAT_DYNAMICS_DERIVATIVE_CORE_DEFINES_SVH
`define TOWED_BOAT_DYNAMICS_DERIVATIVE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TBD_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define TBD_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// ===== rtl/tbd_pkg.sv =====
// types, constants and saturating fixed-point helpers of the towed boat core
// depends on nothing; used by tbd_cordic, the top level and the testbench
package tbd_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    typedef logic signed [31:0] t_q;
    typedef logic signed [32:0] t_q33;
    typedef logic signed [65:0] t_wide;
    typedef logic signed [CORDIC_W-1:0] t_cord;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(34'sh026DD3B6A);

    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // register indexes
    localparam logic [2:0] REG_HULL_RADIUS       = 3'd0;
    localparam logic [2:0] REG_INVERSE_MASS      = 3'd1;
    localparam logic [2:0] REG_INVERSE_INERTIA   = 3'd2;
    localparam logic [2:0] REG_DRAG_LONGITUDINAL = 3'd3;
    localparam logic [2:0] REG_DRAG_CROSSWISE    = 3'd4;
    localparam logic [2:0] REG_DRAG_ROTATIONAL   = 3'd5;

    localparam t_wide SAT_MAX = 66'sd2147483647;
    localparam t_wide SAT_MIN = -66'sd2147483648;

    function automatic t_q sat32(input t_wide v);
        t_q r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // product with a Q2.30 trig value
    function automatic t_q mul_t(input t_q33 a, input t_q33 b);
        t_wide p;
        p = 66'(a) * 66'(b);
        return sat32(p >>> 30);
    endfunction

    // product of two Q values
    function automatic t_q mul_q(input t_q33 a, input t_q33 b);
        t_wide p;
        p = 66'(a) * 66'(b);
        return sat32(p >>> FRAC_BITS);
    endfunction

    // magnitude, exact for the most negative value
    function automatic t_q33 mag33(input t_q v);
        t_q33 e;
        e = 33'(v);
        return (v < 0) ? -e : e;
    endfunction

    function automatic t_q33 coef33(input logic [30:0] c);
        return $signed({2'b00, c});
    endfunction

endpackage

// ===== rtl/tbd_cordic.sv =====
// pipelined rotation cordic: sine and cosine in Q2.30 of a binary angle
// depends on tbd_pkg
module tbd_cordic (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [15:0]   i_angle,
    output tbd_pkg::t_q   o_sin,
    output tbd_pkg::t_q   o_cos
);
    import tbd_pkg::*;

    t_cord       r_x [0:CORDIC_STEPS];
    t_cord       r_y [0:CORDIC_STEPS];
    logic [31:0] r_z [0:CORDIC_STEPS];
    logic        r_f [0:CORDIC_STEPS];
    t_q          r_sin;
    t_q          r_cos;

    logic [31:0] n_z0;
    t_cord       n_c;
    t_cord       n_s;

    // quadrants two and three are folded by a half turn
    assign n_z0 = {i_angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_f[0] <= n_z0[31] ^ n_z0[30];
            r_z[0] <= {n_z0[31] ^ (n_z0[31] ^ n_z0[30]), n_z0[30:0]};
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        t_cord dx;
        t_cord dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[i+1] <= r_f[i];
                if (!r_z[i][31]) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - ATAN_TURNS[i];
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + ATAN_TURNS[i];
                end
            end
        end
    end

    assign n_c = r_f[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    assign n_s = r_f[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_c[31:0];
            r_sin <= n_s[31:0];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== rtl/towed_boat_dynamics_derivative_core.sv =====
// top level of the towed boat dynamics derivative core
// depends on tbd_pkg and tbd_cordic
//
// usage:
//   input channel  : i_valid / o_stall carry one boat state sample per request
//   output channel : o_valid / i_stall carry x, y and yaw acceleration
//   config channel : i_cfg_valid / o_cfg_ready write register i_cfg_index,
//                    always ready, write only while the core is idle
//   pipeline       : 26 cordic stages, 8 arithmetic stages and an output
//                    register between an accepted request and its result
//   throughput     : one request per cycle while no held result stalls it,
//                    set by the fully pipelined cordic and multiplier stages
//   stall          : when the output register holds a result and i_stall is
//                    high the whole pipeline freezes and o_stall rises, so
//                    nothing is lost or repeated
//   reset          : synchronous active low, clears all valid bits and loads
//                    the register defaults (radius, 1/mass, 1/inertia = 1.0,
//                    drag coefficients = 0)
module towed_boat_dynamics_derivative_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_heading_angle,
    input  tbd_pkg::t_q i_velocity_x,
    input  tbd_pkg::t_q i_velocity_y,
    input  tbd_pkg::t_q i_yaw_rate,
    input  tbd_pkg::t_q i_thrust_force,
    input  logic [15:0] i_steer_angle,
    input  tbd_pkg::t_q i_boom_force_x,
    input  tbd_pkg::t_q i_boom_force_y,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output tbd_pkg::t_q o_accel_x,
    output tbd_pkg::t_q o_accel_y,
    output tbd_pkg::t_q o_yaw_accel,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tbd_pkg::*;

    typedef struct packed {
        t_q vx;
        t_q vy;
        t_q om;
        t_q f;
        t_q b1;
        t_q b2;
    } t_side;

    logic en;

    // config registers
    logic [30:0] r_radius, r_inv_mass, r_inv_inertia, r_drag_l, r_drag_c, r_drag_r;

    // side delay alongside the cordic
    t_side r_dly [0:CORDIC_LAT-1];
    logic  [CORDIC_LAT-1:0] r_cv;
    t_q    sh, ch, se, ce;
    t_side d;

    // stage registers
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh, r_vi;
    t_q r_a_vxs, r_a_vyc, r_a_vxc, r_a_vys, r_a_b1s, r_a_b2c, r_a_b1c, r_a_b2s;
    t_q r_a_fc, r_a_fs, r_a_omq, r_a_omvx, r_a_omvy, r_a_om, r_a_sh, r_a_ch;
    t_q r_b_u, r_b_v, r_b_bu, r_b_bv, r_b_fc, r_b_fs, r_b_omq, r_b_omvx, r_b_omvy;
    t_q r_b_om, r_b_sh, r_b_ch;
    t_q r_c_uq, r_c_vq, r_c_rfs, r_c_rbv, r_c_dr, r_c_u, r_c_v, r_c_fc, r_c_fs;
    t_q r_c_bu, r_c_bv, r_c_om, r_c_omvx, r_c_omvy, r_c_sh, r_c_ch;
    t_q r_d_dl, r_d_dc, r_d_omv, r_d_omu, r_d_fc, r_d_fs, r_d_bu, r_d_bv;
    t_q r_d_rfs, r_d_rbv, r_d_dr, r_d_omvx, r_d_omvy, r_d_sh, r_d_ch;
    t_q r_e_fu, r_e_fv, r_e_tq, r_e_omv, r_e_omu, r_e_omvx, r_e_omvy, r_e_sh, r_e_ch;
    t_q r_f_fum, r_f_fvm, r_f_wd, r_f_omv, r_f_omu, r_f_omvx, r_f_omvy, r_f_sh, r_f_ch;
    t_q r_g_ud, r_g_vd, r_g_wd, r_g_omvx, r_g_omvy, r_g_sh, r_g_ch;
    t_q r_h_p1, r_h_p2, r_h_p3, r_h_p4, r_h_wd, r_h_omvx, r_h_omvy;
    t_q r_ax, r_ay, r_wd;

    // the pipeline moves unless a finished result is held back
    assign en          = !(r_vi && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= 31'd65536;
            r_inv_mass    <= 31'd65536;
            r_inv_inertia <= 31'd65536;
            r_drag_l      <= '0;
            r_drag_c      <= '0;
            r_drag_r      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HULL_RADIUS:       r_radius      <= i_cfg_data[30:0];
                REG_INVERSE_MASS:      r_inv_mass    <= i_cfg_data[30:0];
                REG_INVERSE_INERTIA:   r_inv_inertia <= i_cfg_data[30:0];
                REG_DRAG_LONGITUDINAL: r_drag_l      <= i_cfg_data[30:0];
                REG_DRAG_CROSSWISE:    r_drag_c      <= i_cfg_data[30:0];
                REG_DRAG_ROTATIONAL:   r_drag_r      <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // heading and steering trig
    tbd_cordic u_cordic_head (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_heading_angle),
        .o_sin   (sh),
        .o_cos   (ch)
    );

    tbd_cordic u_cordic_steer (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_steer_angle),
        .o_sin   (se),
        .o_cos   (ce)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= '{vx: i_velocity_x, vy: i_velocity_y, om: i_yaw_rate,
                          f: i_thrust_force, b1: i_boom_force_x, b2: i_boom_force_y};
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign d = r_dly[CORDIC_LAT-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
            {r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh, r_vi} <= '0;
        end else if (en) begin
            r_cv <= {r_cv[CORDIC_LAT-2:0], i_valid};
            {r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh, r_vi} <=
                {r_cv[CORDIC_LAT-1], r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // rotate velocity and boom force into the boat frame, thrust split, yaw rate products
            r_a_vxs  <= mul_t(33'(d.vx), 33'(sh));
            r_a_vyc  <= mul_t(33'(d.vy), 33'(ch));
            r_a_vxc  <= mul_t(33'(d.vx), 33'(ch));
            r_a_vys  <= mul_t(33'(d.vy), 33'(sh));
            r_a_b1s  <= mul_t(33'(d.b1), 33'(sh));
            r_a_b2c  <= mul_t(33'(d.b2), 33'(ch));
            r_a_b1c  <= mul_t(33'(d.b1), 33'(ch));
            r_a_b2s  <= mul_t(33'(d.b2), 33'(sh));
            r_a_fc   <= mul_t(33'(d.f), 33'(ce));
            r_a_fs   <= mul_t(33'(d.f), 33'(se));
            r_a_omq  <= mul_q(33'(d.om), mag33(d.om));
            r_a_omvx <= mul_q(33'(d.om), 33'(d.vx));
            r_a_omvy <= mul_q(33'(d.om), 33'(d.vy));
            r_a_om   <= d.om;
            r_a_sh   <= sh;
            r_a_ch   <= ch;

            // boat-frame velocity and boom load
            r_b_u    <= sat32(66'(r_a_vxs) + 66'(r_a_vyc));
            r_b_v    <= sat32(66'(r_a_vxc) - 66'(r_a_vys));
            r_b_bu   <= sat32(66'(r_a_b1s) + 66'(r_a_b2c));
            r_b_bv   <= sat32(66'(r_a_b1c) - 66'(r_a_b2s));
            r_b_fc   <= r_a_fc;
            r_b_fs   <= r_a_fs;
            r_b_omq  <= r_a_omq;
            r_b_omvx <= r_a_omvx;
            r_b_omvy <= r_a_omvy;
            r_b_om   <= r_a_om;
            r_b_sh   <= r_a_sh;
            r_b_ch   <= r_a_ch;

            // signed squares, lever arm products, yaw damping
            r_c_uq   <= mul_q(33'(r_b_u), mag33(r_b_u));
            r_c_vq   <= mul_q(33'(r_b_v), mag33(r_b_v));
            r_c_rfs  <= mul_q(coef33(r_radius), 33'(r_b_fs));
            r_c_rbv  <= mul_q(coef33(r_radius), 33'(r_b_bv));
            r_c_dr   <= mul_q(coef33(r_drag_r), 33'(r_b_omq));
            r_c_u    <= r_b_u;
            r_c_v    <= r_b_v;
            r_c_fc   <= r_b_fc;
            r_c_fs   <= r_b_fs;
            r_c_bu   <= r_b_bu;
            r_c_bv   <= r_b_bv;
            r_c_om   <= r_b_om;
            r_c_omvx <= r_b_omvx;
            r_c_omvy <= r_b_omvy;
            r_c_sh   <= r_b_sh;
            r_c_ch   <= r_b_ch;

            // hull drag and coriolis terms
            r_d_dl   <= mul_q(coef33(r_drag_l), 33'(r_c_uq));
            r_d_dc   <= mul_q(coef33(r_drag_c), 33'(r_c_vq));
            r_d_omv  <= mul_q(33'(r_c_om), 33'(r_c_v));
            r_d_omu  <= mul_q(33'(r_c_om), 33'(r_c_u));
            r_d_fc   <= r_c_fc;
            r_d_fs   <= r_c_fs;
            r_d_bu   <= r_c_bu;
            r_d_bv   <= r_c_bv;
            r_d_rfs  <= r_c_rfs;
            r_d_rbv  <= r_c_rbv;
            r_d_dr   <= r_c_dr;
            r_d_omvx <= r_c_omvx;
            r_d_omvy <= r_c_omvy;
            r_d_sh   <= r_c_sh;
            r_d_ch   <= r_c_ch;

            // net forces and torque
            r_e_fu   <= sat32(66'(r_d_fc) - 66'(r_d_dl) + 66'(r_d_bu));
            r_e_fv   <= sat32(-66'(r_d_fs) - 66'(r_d_dc) + 66'(r_d_bv));
            r_e_tq   <= sat32(66'(r_d_rfs) - 66'(r_d_dr) - 66'(r_d_rbv));
            r_e_omv  <= r_d_omv;
            r_e_omu  <= r_d_omu;
            r_e_omvx <= r_d_omvx;
            r_e_omvy <= r_d_omvy;
            r_e_sh   <= r_d_sh;
            r_e_ch   <= r_d_ch;

            // scale by reciprocal mass and inertia
            r_f_fum  <= mul_q(33'(r_e_fu), coef33(r_inv_mass));
            r_f_fvm  <= mul_q(33'(r_e_fv), coef33(r_inv_mass));
            r_f_wd   <= mul_q(33'(r_e_tq), coef33(r_inv_inertia));
            r_f_omv  <= r_e_omv;
            r_f_omu  <= r_e_omu;
            r_f_omvx <= r_e_omvx;
            r_f_omvy <= r_e_omvy;
            r_f_sh   <= r_e_sh;
            r_f_ch   <= r_e_ch;

            // boat-frame accelerations
            r_g_ud   <= sat32(66'(r_f_fum) + 66'(r_f_omv));
            r_g_vd   <= sat32(66'(r_f_fvm) - 66'(r_f_omu));
            r_g_wd   <= r_f_wd;
            r_g_omvx <= r_f_omvx;
            r_g_omvy <= r_f_omvy;
            r_g_sh   <= r_f_sh;
            r_g_ch   <= r_f_ch;

            // rotate back to the global frame
            r_h_p1   <= mul_t(33'(r_g_ud), 33'(r_g_sh));
            r_h_p2   <= mul_t(33'(r_g_vd), 33'(r_g_ch));
            r_h_p3   <= mul_t(33'(r_g_ud), 33'(r_g_ch));
            r_h_p4   <= mul_t(33'(r_g_vd), 33'(r_g_sh));
            r_h_wd   <= r_g_wd;
            r_h_omvx <= r_g_omvx;
            r_h_omvy <= r_g_omvy;

            // output register
            r_ax     <= sat32(66'(r_h_p1) + 66'(r_h_p2) + 66'(r_h_omvx));
            r_ay     <= sat32(66'(r_h_p3) - 66'(r_h_p4) - 66'(r_h_omvy));
            r_wd     <= r_h_wd;
        end
    end

    assign o_valid     = r_vi;
    assign o_accel_x   = r_ax;
    assign o_accel_y   = r_ay;
    assign o_yaw_accel = r_wd;

endmodule

// ===== rtl/tbd_checker.sv =====
// port-level checker for the towed boat derivative core, bound to the top
// depends on towed_boat_dynamics_derivative_core_defines.svh
`include "towed_boat_dynamics_derivative_core_defines.svh"

module tbd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_stall,
    input logic o_valid,
    input logic o_stall,
    input logic o_cfg_ready
);

    // a held result keeps its valid
    `TBD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // input stalls only when a finished result is held back
    `TBD_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // no result right after reset
    `TBD_ASSERT_NXT(a_reset_clear, i_clk, 1'b1, !i_rst_n, !o_valid)

    // register writes are never refused
    `TBD_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready)

endmodule

bind towed_boat_dynamics_derivative_core tbd_checker u_tbd_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench of towed_boat_dynamics_derivative_core
// depends on tbd_pkg and the core; predicts accelerations in a scoreboard class
module tb_top;
    import tbd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int DRAIN_CYCLES   = 45;    // more than the pipeline depth
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
    localparam int LONG_HOLD      = 300;   // receiver hold-off that fills the pipe
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 210;
    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    // one boat state sample
    typedef struct {
        logic [15:0] heading;
        t_q          vel_x;
        t_q          vel_y;
        t_q          yaw_rate;
        t_q          thrust;
        logic [15:0] steer;
        t_q          boom_x;
        t_q          boom_y;
    } boat_sample_t;

    // one acceleration result
    typedef struct {
        t_q acc_x;
        t_q acc_y;
        t_q acc_yaw;
    } boat_accel_t;

    // predicts accelerations from accepted requests and checks results in order
    class accel_scoreboard;
        boat_accel_t pending_accel[$];
        logic [30:0] coef[0:5];
        int          fails;
        logic [31:0] atan_tab[0:23];

        function new();
            atan_tab = '{
                32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
                32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
            fails = 0;
            load_defaults();
        endfunction

        function void load_defaults();
            coef[REG_HULL_RADIUS]       = 31'd65536;
            coef[REG_INVERSE_MASS]      = 31'd65536;
            coef[REG_INVERSE_INERTIA]   = 31'd65536;
            coef[REG_DRAG_LONGITUDINAL] = 31'd0;
            coef[REG_DRAG_CROSSWISE]    = 31'd0;
            coef[REG_DRAG_ROTATIONAL]   = 31'd0;
        endfunction

        // out-of-range indexes leave the registers alone, bit 31 is dropped
        function void write_reg(logic [2:0] idx, logic [31:0] data);
            if (idx <= REG_DRAG_ROTATIONAL)
                coef[idx] = data[30:0];
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint trig_mul(longint a, longint t);
            return clip32((a * t) >>> 30);
        endfunction

        function longint fix_mul(longint a, longint b);
            return clip32((a * b) >>> FRAC_BITS);
        endfunction

        // signed quadratic drag, magnitude of the most negative speed kept exact
        function longint quad_drag(longint c, longint q);
            longint mag;
            mag = (q < 0) ? -q : q;
            return fix_mul(c, fix_mul(q, mag));
        endfunction

        // cordic sine and cosine in Q2.30, quadrants two and three folded over
        function void sin_cos(logic [15:0] ang, output longint s, output longint c);
            logic [31:0] z;
            bit          flip;
            longint      x, y, dx, dy;
            z = {ang, 16'h0000};
            flip = 0;
            x = 64'sh26DD3B6A;
            y = 0;
            if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
                z = z + 32'h80000000;
                flip = 1;
            end
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z < 32'h80000000) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_tab[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_tab[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function boat_accel_t predict_accel(boat_sample_t s);
            longint sh, ch, se, ce, vx, vy, om, f, b1, b2, r;
            longint u, v, bu, bv, fc, fs, fu, fv, tq, ud, vd, wd;
            boat_accel_t a;
            vx = longint'(s.vel_x);
            vy = longint'(s.vel_y);
            om = longint'(s.yaw_rate);
            f  = longint'(s.thrust);
            b1 = longint'(s.boom_x);
            b2 = longint'(s.boom_y);
            r  = longint'(coef[REG_HULL_RADIUS]);
            sin_cos(s.heading, sh, ch);
            sin_cos(s.steer, se, ce);
            // into the boat frame
            u  = clip32(trig_mul(vx, sh) + trig_mul(vy, ch));
            v  = clip32(trig_mul(vx, ch) - trig_mul(vy, sh));
            bu = clip32(trig_mul(b1, sh) + trig_mul(b2, ch));
            bv = clip32(trig_mul(b1, ch) - trig_mul(b2, sh));
            fc = trig_mul(f, ce);
            fs = trig_mul(f, se);
            // forces and torque
            fu = clip32(fc - quad_drag(coef[REG_DRAG_LONGITUDINAL], u) + bu);
            fv = clip32(-fs - quad_drag(coef[REG_DRAG_CROSSWISE], v) + bv);
            tq = clip32(fix_mul(r, fs) - quad_drag(coef[REG_DRAG_ROTATIONAL], om)
                        - fix_mul(r, bv));
            ud = clip32(fix_mul(fu, coef[REG_INVERSE_MASS]) + fix_mul(om, v));
            vd = clip32(fix_mul(fv, coef[REG_INVERSE_MASS]) - fix_mul(om, u));
            wd = fix_mul(tq, coef[REG_INVERSE_INERTIA]);
            // back to the global frame
            a.acc_x   = t_q'(clip32(trig_mul(ud, sh) + trig_mul(vd, ch) + fix_mul(om, vx)));
            a.acc_y   = t_q'(clip32(trig_mul(ud, ch) - trig_mul(vd, sh) - fix_mul(om, vy)));
            a.acc_yaw = t_q'(wd);
            return a;
        endfunction

        function void note_request(boat_sample_t s);
            pending_accel.push_back(predict_accel(s));
        endfunction

        // one line per mismatch, counted
        task report_mismatch(string msg);
            $display("error: %s", msg);
            fails++;
        endtask

        task check_result(t_q ax, t_q ay, t_q aw);
            boat_accel_t e;
            if (pending_accel.size() == 0) begin
                report_mismatch($sformatf("result %h %h %h with no request outstanding",
                                          ax, ay, aw));
                return;
            end
            e = pending_accel.pop_front();
            if (ax !== e.acc_x)
                report_mismatch($sformatf("accel_x got %h expected %h", ax, e.acc_x));
            if (ay !== e.acc_y)
                report_mismatch($sformatf("accel_y got %h expected %h", ay, e.acc_y));
            if (aw !== e.acc_yaw)
                report_mismatch($sformatf("yaw_accel got %h expected %h", aw, e.acc_yaw));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_heading_angle;
    t_q          i_velocity_x;
    t_q          i_velocity_y;
    t_q          i_yaw_rate;
    t_q          i_thrust_force;
    logic [15:0] i_steer_angle;
    t_q          i_boom_force_x;
    t_q          i_boom_force_y;
    logic        o_valid;
    logic        i_stall;
    t_q          o_accel_x;
    t_q          o_accel_y;
    t_q          o_yaw_accel;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    accel_scoreboard sb;
    int  results_seen;
    bit  hold_done;
    bit  no_gaps;      // sender runs back to back for a whole phase
    int  idle_cycles;

    towed_boat_dynamics_derivative_core dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // watchdog: any handshake on any channel resets the count
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("towed_boat_dynamics_derivative_core: mismatch");
                $finish;
            end
        end
    end

    // result monitor, sampled at the rising edge
    initial begin
        results_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                sb.check_result(o_accel_x, o_accel_y, o_yaw_accel);
                results_seen++;
            end
        end
    end

    // receiver stall: mostly short, a few long, free-running stretches,
    // and one long hold-off while the sender keeps pushing
    initial begin
        int r;
        i_stall = 1'b0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (!hold_done && results_seen >= 300) begin
                i_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done = 1;
                i_stall = 1'b0;
            end else if (r < 4) begin
                i_stall = 1'b0;
                repeat ($urandom_range(50, 150)) @(negedge i_clk);
            end else if (r < 60) begin
                i_stall = 1'b0;
            end else if (r < 95) begin
                i_stall = 1'b1;
                repeat ($urandom_range(0, 2)) @(negedge i_clk);
            end else begin
                i_stall = 1'b1;
                repeat ($urandom_range(8, 40)) @(negedge i_clk);
            end
        end
    end

    // fixed-point field: extremes, zero, small magnitudes, full range
    function automatic t_q pick_q();
        case ($urandom_range(0, 9))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2: return 32'sh00000000;
            3, 4, 5: return t_q'($signed($urandom_range(0, 32'h003FFFFF)) - 32'sh00200000);
            default: return t_q'($urandom());
        endcase
    endfunction

    // binary angle: quadrant edges now and then, else anything
    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        a = 16'($urandom());
        if ($urandom_range(0, 7) == 0)
            a = {a[15:14], 14'h0000} + 16'($urandom_range(0, 2)) - 16'd1;
        return a;
    endfunction

    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(0, 7))
            0: return 32'h00000000;
            1: return 32'h7FFFFFFF;
            2: return 32'hFFFFFFFF;   // top bit must be dropped
            3: return 32'h00010000;
            4: return 32'($urandom_range(0, 32'h0003FFFF));
            default: return $urandom();
        endcase
    endfunction

    // sender gap after each request: mostly none or short, a few long
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = 0;
        if (!no_gaps) begin
            if (r < 35)
                n = $urandom_range(1, 3);
            else if (r < 40)
                n = $urandom_range(8, 40);
        end
        if (n > 0) begin
            i_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // drive one request, starting and ending at a falling edge
    task automatic send_sample(boat_sample_t s);
        i_heading_angle = s.heading;
        i_velocity_x    = s.vel_x;
        i_velocity_y    = s.vel_y;
        i_yaw_rate      = s.yaw_rate;
        i_thrust_force  = s.thrust;
        i_steer_angle   = s.steer;
        i_boom_force_x  = s.boom_x;
        i_boom_force_y  = s.boom_y;
        i_valid         = 1'b1;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_request(s);
        @(negedge i_clk);
        sender_gap();
    endtask

    task automatic send_fields(logic [15:0] h, t_q vx, t_q vy, t_q om, t_q f,
                               logic [15:0] st, t_q bx, t_q by);
        boat_sample_t s;
        s.heading = h;   s.vel_x = vx;  s.vel_y = vy;  s.yaw_rate = om;
        s.thrust = f;    s.steer = st;  s.boom_x = bx; s.boom_y = by;
        send_sample(s);
    endtask

    task automatic send_random();
        send_fields(pick_angle(), pick_q(), pick_q(), pick_q(), pick_q(),
                    pick_angle(), pick_q(), pick_q());
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // registers change only with the pipeline empty
    task automatic wait_idle();
        i_valid = 1'b0;
        while (sb.pending_accel.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] v;
        sb = new();
        no_gaps = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_HULL_RADIUS;
        i_cfg_data = '0;
        i_heading_angle = '0;
        i_velocity_x = '0;
        i_velocity_y = '0;
        i_yaw_rate = '0;
        i_thrust_force = '0;
        i_steer_angle = '0;
        i_boom_force_x = '0;
        i_boom_force_y = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed, reset defaults: zero, extremes, quadrant edges
        send_fields(16'h0000, 0, 0, 0, 0, 16'h0000, 0, 0);
        send_fields(16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                    16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_fields(16'h8000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                    16'h8000, 32'sh80000000, 32'sh80000000);
        send_fields(16'h4000, 32'sh00010000, 0, 0, 32'sh00010000, 16'h4000, 0, 0);
        send_fields(16'hC000, 0, 32'sh00010000, 32'sh00010000, 32'sh00010000,
                    16'hC000, 32'sh00010000, 0);
        send_fields(16'h3FFF, 32'sh00020000, -32'sh00020000, 32'sh00008000, -32'sh00010000,
                    16'h7FFF, 0, 32'sh00010000);
        send_fields(16'hBFFF, 32'sh7FFFFFFF, 32'sh80000000, -32'sh00010000, 32'sh7FFFFFFF,
                    16'h2000, 32'sh80000000, 32'sh7FFFFFFF);
        send_fields(16'h5555, 32'sh0, 32'sh0, 32'sh7FFFFFFF, 32'sh0, 16'hAAAA, 0, 0);
        wait_idle();

        // directed, drag on: the most negative speed in every drag term
        write_reg(REG_DRAG_LONGITUDINAL, 32'h00010000);
        write_reg(REG_DRAG_CROSSWISE, 32'h00000001);
        write_reg(REG_DRAG_ROTATIONAL, 32'h7FFFFFFF);
        write_reg(REG_UNUSED_LO, 32'h12345678);
        write_reg(REG_UNUSED_HI, 32'hFFFFFFFF);
        send_fields(16'h0000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 16'h0000, 0, 0);
        send_fields(16'h4000, 32'sh80000000, 0, 32'sh00000100, 0, 16'h0000, 0, 0);
        send_fields(16'h0000, 0, 32'sh80000000, -32'sh00000100, 0, 16'h0000, 0, 0);
        send_fields(16'h2000, 32'sh00000300, -32'sh00000300, 32'sh00000001, 0, 16'h0000, 0, 0);
        wait_idle();

        // random phases, the last two at the register extremes (inverse mass 1.0 in the zero phase)
        for (int p = 0; p < PHASES; p++) begin
            for (int k = 0; k <= REG_DRAG_ROTATIONAL; k++) begin
                if (p == PHASES - 2)
                    v = 32'h00000000;
                else if (p == PHASES - 1)
                    v = 32'h7FFFFFFF;
                else
                    v = pick_reg_value();
                write_reg(3'(k), v);
            end
            if (p == PHASES - 2)
                write_reg(REG_INVERSE_MASS, 32'h00010000);
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom());
            no_gaps = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random();
            wait_idle();
        end

        i_valid = 1'b0;
        while (sb.pending_accel.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.fails == 0)
            $display("towed_boat_dynamics_derivative_core: match");
        else
            $display("towed_boat_dynamics_derivative_core: mismatch");
        $finish;
    end

endmodule
